FILE: rtl/core/sssd_pkg.sv
`timescale 1ns / 1ps
// sssd_pkg: shared types, codes and the decimal segment table of the
// seven-segment scan driver; no dependencies

package sssd_pkg;

   // request kinds carried on req_tuser
   localparam logic [1:0] REQ_TICK      = 2'd0;
   localparam logic [1:0] REQ_SHOW_HIGH = 2'd1;
   localparam logic [1:0] REQ_SHOW_LOW  = 2'd2;

   // configuration register indexes
   localparam logic CSR_DIGIT0 = 1'b0;
   localparam logic CSR_DIGIT1 = 1'b1;

   localparam int VALUE_W     = 16;
   localparam int RESID_W     = 10;
   localparam int PATTERN_W   = 8;
   localparam int DIGIT_W     = 3;
   localparam int STORE_DEPTH = 6;

   localparam logic [VALUE_W-1:0]   VALUE_CLAMP  = 16'd999;
   localparam logic [RESID_W-1:0]   STEP_HUND    = 10'd100;
   localparam logic [RESID_W-1:0]   STEP_TENS    = 10'd10;
   localparam logic [PATTERN_W-1:0] PATTERN_INIT = 8'hFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_HUND,
      ST_TENS
   } state_type;

   // decimal digit to segment pattern
   function automatic logic [PATTERN_W-1:0] seg_of(input logic [3:0] d);
      logic [PATTERN_W-1:0] p;
      unique case (d)
         4'd0:    p = 8'hFC;
         4'd1:    p = 8'h60;
         4'd2:    p = 8'hDA;
         4'd3:    p = 8'hF2;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'hB6;
         4'd6:    p = 8'hBE;
         4'd7:    p = 8'hE0;
         4'd8:    p = 8'hFE;
         4'd9:    p = 8'hF6;
         default: p = 8'h00;
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/core/seven_segment_scan_driver.sv
`timescale 1ns / 1ps
// seven_segment_scan_driver: eight-digit multiplexed display driver with a
// repeated-subtraction decimal splitter; depends on sssd_pkg
//
//   channel | ports                        | carries
//   --------+------------------------------+----------------------------------
//   req     | req_tvalid/tready/tdata/tuser| request kind, value to show
//   rsp     | rsp_tvalid/tready/tdata      | frame word, digit index
//   csr     | csr_we/index/wdata           | patterns for digits zero and one
//
// a tick request leaves its frame in the output register
// a show request runs a hundreds pass and then a tens pass: the
// shared subtract-and-compare unit removes one hundred or one ten per cycle
// reset clears the scan index, the digit store and the csr patterns (to 0xff)
// req_tready is low while a split is running or a frame waits unaccepted

module seven_segment_scan_driver (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [sssd_pkg::VALUE_W-1:0] req_tdata,   // [15:0] value
   input  logic [1:0]                   req_tuser,   // [1:0] req_type
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,   // [15:0] frame, [18:16] digit_index
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [sssd_pkg::PATTERN_W-1:0] csr_wdata
);
   import sssd_pkg::*;

   // sequencer and split datapath
   state_type            state_ff, state_in;
   logic [RESID_W-1:0]   resid_ff, resid_in;
   logic [3:0]           hund_ff, hund_in;
   logic [3:0]           tens_ff, tens_in;
   logic                 group_ff, group_in;   // 1: high group (digits 7..5)

   // display state
   logic [PATTERN_W-1:0] store_ff [STORE_DEPTH];
   logic [DIGIT_W-1:0]   scan_ff, scan_in;
   logic [PATTERN_W-1:0] digit0_ff, digit1_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          frame_ff, frame_in;
   logic [DIGIT_W-1:0]   index_ff;

   // control
   logic                 req_fire;
   logic                 tick_fire;
   logic                 load_split;
   logic                 step_take;
   logic                 store_write;

   // shared subtract and compare unit
   logic [RESID_W-1:0]   step_amount;
   logic [RESID_W-1:0]   step_diff;
   logic                 step_ge;

   logic [VALUE_W-1:0]   clamped;
   logic [PATTERN_W-1:0] pattern_sel;
   logic [DIGIT_W-1:0]   store_addr;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign tick_fire  = req_fire && (req_tuser == REQ_TICK);
   assign load_split = req_fire && ((req_tuser == REQ_SHOW_HIGH) ||
                                    (req_tuser == REQ_SHOW_LOW));

   assign step_amount = (state_ff == ST_HUND) ? STEP_HUND : STEP_TENS;
   assign step_ge     = resid_ff >= step_amount;
   assign step_diff   = resid_ff - step_amount;

   assign clamped = (req_tdata > VALUE_CLAMP) ? VALUE_CLAMP : req_tdata;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (load_split) state_in = ST_HUND;
         end
         ST_HUND: begin
            if (!step_ge) state_in = ST_TENS;
         end
         ST_TENS: begin
            if (!step_ge) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      step_take   = 1'b0;
      store_write = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_HUND: step_take = step_ge;
         ST_TENS: begin
            step_take   = step_ge;
            store_write = !step_ge;
         end
         default: ;
      endcase
   end

   // split datapath next values
   always_comb begin
      resid_in = resid_ff;
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      group_in = group_ff;
      if (load_split) begin
         resid_in = clamped[RESID_W-1:0];
         hund_in  = 4'd0;
         tens_in  = 4'd0;
         group_in = (req_tuser == REQ_SHOW_HIGH);
      end else if (step_take) begin
         resid_in = step_diff;
         if (state_ff == ST_HUND) hund_in = hund_ff + 4'd1;
         else                     tens_in = tens_ff + 4'd1;
      end
   end

   // scan: advance first, then pick the pattern of the new position
   assign scan_in    = scan_ff + DIGIT_W'(1);
   assign store_addr = scan_in - DIGIT_W'(2);

   always_comb begin
      priority if (scan_in == DIGIT_W'(0)) pattern_sel = digit0_ff;
      else if (scan_in == DIGIT_W'(1))     pattern_sel = digit1_ff;
      else                                 pattern_sel = store_ff[store_addr];
   end

   assign frame_in = {pattern_sel, ~(8'd1 << scan_in)};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tick_fire)       rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         digit0_ff    <= PATTERN_INIT;
         digit1_ff    <= PATTERN_INIT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tick_fire) scan_ff <= scan_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_DIGIT0: digit0_ff <= csr_wdata;
               CSR_DIGIT1: digit1_ff <= csr_wdata;
               default:    ;
            endcase
         end
      end
   end

   // digit store, blank after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STORE_DEPTH; k++) store_ff[k] <= '0;
      end else if (store_write) begin
         if (group_ff) begin
            store_ff[5] <= seg_of(hund_ff);
            store_ff[4] <= seg_of(tens_ff);
            store_ff[3] <= seg_of(resid_ff[3:0]);
         end else begin
            store_ff[2] <= seg_of(hund_ff);
            store_ff[1] <= seg_of(tens_ff);
            store_ff[0] <= seg_of(resid_ff[3:0]);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      resid_ff <= resid_in;
      hund_ff  <= hund_in;
      tens_ff  <= tens_in;
      group_ff <= group_in;
      if (tick_fire) begin
         frame_ff <= frame_in;
         index_ff <= scan_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, index_ff, frame_ff};

   // checks

   // a tick always leaves a frame waiting in the next cycle
   a_tick_gives_frame: assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> rsp_tvalid)
      else $error("tick request produced no frame");

   // exactly one anode is driven low
   a_one_anode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($countones(rsp_tdata[7:0]) == 7))
      else $error("anode mask is not one-cold");

   // hundreds are all gone before the tens pass
   a_tens_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TENS) |-> (resid_ff < STEP_HUND))
      else $error("residue too large in tens pass");

   // digit counters never leave the decimal range while splitting
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((hund_ff <= 4'd9) && (tens_ff <= 4'd9)))
      else $error("decimal digit counter out of range");

endmodule
